FILE: rtl/lc3b_pkg.sv
// Package for the LC-3b instruction executor: field widths, opcodes, item kinds,
// and the command/status structs between the controller and the datapath.
// No dependencies.
package lc3b_pkg;

   localparam int MemWordsDefault = 32768;
   localparam int RegCountDefault = 8;

   localparam logic [1:0] KIND_LOAD = 2'd0;
   localparam logic [1:0] KIND_SETPC = 2'd1;
   localparam logic [1:0] KIND_EXEC = 2'd2;

   localparam logic [3:0] OP_BR   = 4'd0;
   localparam logic [3:0] OP_ADD  = 4'd1;
   localparam logic [3:0] OP_LDB  = 4'd2;
   localparam logic [3:0] OP_STB  = 4'd3;
   localparam logic [3:0] OP_JSR  = 4'd4;
   localparam logic [3:0] OP_AND  = 4'd5;
   localparam logic [3:0] OP_LDW  = 4'd6;
   localparam logic [3:0] OP_STW  = 4'd7;
   localparam logic [3:0] OP_XOR  = 4'd9;
   localparam logic [3:0] OP_JMP  = 4'd12;
   localparam logic [3:0] OP_SHF  = 4'd13;
   localparam logic [3:0] OP_LEA  = 4'd14;
   localparam logic [3:0] OP_TRAP = 4'd15;

   localparam logic [2:0] CC_RESET = 3'b010;

   typedef struct packed {
      logic        halted;
      logic [15:0] pc_after;
      logic [3:0]  opcode_done;
      logic        reg_written;
      logic [2:0]  reg_index;
      logic [15:0] reg_value;
      logic [2:0]  cond_nzp;
      logic        store_done;
      logic [15:0] store_address;
      logic [15:0] store_value;
   } result_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_step;   // write zero to the clear pointer's word
      logic load_word;    // write a load item's word
      logic set_pc;
      logic halt_result;  // build a halted/no-op result for the current item
      logic fetch;        // read the instruction word at PC
      logic decode;       // latch instruction, read registers
      logic mem_read;     // read the data word (or trap vector)
      logic commit;       // write back, form the result
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic pc_zero;
   } status_type;

endpackage

FILE: rtl/lc3b_ctrl.sv
// Controller state machine of the LC-3b executor: clearing pass, handshake and
// the fetch/decode/commit sequence. Depends on lc3b_pkg.
module lc3b_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [1:0]           req_kind,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  lc3b_pkg::status_type status,
   output lc3b_pkg::cmd_type    cmd
);
   import lc3b_pkg::*;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_FETCH  = 3'd2;
   localparam logic [2:0] ST_DECODE = 3'd3;
   localparam logic [2:0] ST_COMMIT = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       accept;

   assign req_tready = (state_ff == ST_IDLE) && !valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff && !rsp_tready;
      cmd = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_EXEC && !status.pc_zero) begin
                  cmd.fetch = 1'b1;
                  state_in  = ST_FETCH;
               end else begin
                  cmd.load_word   = (req_kind == KIND_LOAD);
                  cmd.set_pc      = (req_kind == KIND_SETPC);
                  cmd.halt_result = 1'b1;
                  valid_in        = 1'b1;
               end
            end
         end
         ST_FETCH: begin
            cmd.decode = 1'b1;
            state_in   = ST_DECODE;
         end
         ST_DECODE: begin
            // The data word (or trap vector) is registered at the end of this cycle.
            cmd.mem_read = 1'b1;
            state_in     = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            valid_in   = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> !req_tready) else $error("item accepted while a result waits");
   a_commit_after_decode: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COMMIT |-> $past(state_ff) == ST_DECODE)
      else $error("commit without decode phase");
   a_fetch_after_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FETCH |-> $past(accept))
      else $error("fetch without accepted item");
endmodule

FILE: rtl/lc3b_dpath.sv
// Datapath of the LC-3b executor: word memory, register file, PC, condition
// codes, address and ALU logic and the result register. Depends on lc3b_pkg.
module lc3b_dpath #(
   parameter int MEM_WORDS = lc3b_pkg::MemWordsDefault,
   parameter int REG_COUNT = lc3b_pkg::RegCountDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lc3b_pkg::cmd_type    cmd,
   output lc3b_pkg::status_type status,
   input  logic [1:0]           req_kind,
   input  logic [14:0]          req_load_word_address,
   input  logic [15:0]          req_load_word_value,
   input  logic [15:0]          req_start_pc,
   output lc3b_pkg::result_type result
);
   import lc3b_pkg::*;

   localparam int AW = $clog2(MEM_WORDS);
   localparam int RW = $clog2(REG_COUNT);

   logic [15:0] mem [MEM_WORDS];
   logic [15:0] rdata_ff;
   logic [AW:0] clr_ff;

   logic [15:0] regs_ff [REG_COUNT];
   logic [15:0] pc_ff;
   logic [2:0]  cc_ff;
   logic [15:0] ins_ff, a_ff, b_ff, src_ff, addr_ff;
   result_type  res_ff;

   // Memory port multiplexing: one write and one read address per cycle.
   logic          we;
   logic [AW-1:0] waddr, raddr;
   logic [15:0]   wdata;

   logic [3:0]  opc;
   logic [2:0]  dr;
   logic [15:0] npc, off9, off11, a_in, b_in, addr_in;
   logic [15:0] rval, npc_out, sval, bytev;
   logic        rwr, cc_upd, sd;
   logic [2:0]  ridx, cc_new;

   assign status.clear_done = (clr_ff == (AW+1)'(MEM_WORDS - 1));
   assign status.pc_zero    = (pc_ff == 16'd0);

   assign opc   = ins_ff[15:12];
   assign dr    = ins_ff[11:9];
   assign npc   = pc_ff + 16'd2;
   assign off9  = {{7{ins_ff[8]}}, ins_ff[8:0]};
   assign off11 = {{5{ins_ff[10]}}, ins_ff[10:0]};

   // Decode-phase operands, computed from the freshly latched instruction.
   logic [15:0] ins_d;
   assign ins_d = rdata_ff;
   assign a_in  = regs_ff[RW'(ins_d[8:6])];
   assign b_in  = ins_d[5] ? {{11{ins_d[4]}}, ins_d[4:0]} : regs_ff[RW'(ins_d[2:0])];
   always_comb begin
      if (ins_d[15:12] == OP_LDB || ins_d[15:12] == OP_STB)
         addr_in = a_in + {{10{ins_d[5]}}, ins_d[5:0]};
      else if (ins_d[15:12] == OP_TRAP)
         addr_in = {7'd0, ins_d[7:0], 1'b0};
      else
         addr_in = a_in + {{9{ins_d[5]}}, ins_d[5:0], 1'b0};
   end

   always_comb begin
      we = 1'b0;
      waddr = AW'(req_load_word_address);
      wdata = req_load_word_value;
      raddr = AW'(pc_ff[15:1]);
      if (cmd.clear_step) begin
         we = 1'b1;
         waddr = clr_ff[AW-1:0];
         wdata = 16'd0;
      end else if (cmd.load_word) begin
         we = 1'b1;
      end else if (cmd.mem_read) begin
         raddr = AW'(addr_in[15:1]);
      end else if (cmd.commit && sd) begin
         we = 1'b1;
         waddr = AW'(addr_ff[15:1]);
         wdata = (opc == OP_STB)
                 ? (addr_ff[0] ? {sval[7:0], rdata_ff[7:0]} : {rdata_ff[15:8], sval[7:0]})
                 : sval;
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   always_comb begin
      rwr = 1'b0;
      cc_upd = 1'b0;
      sd = 1'b0;
      ridx = dr;
      rval = 16'd0;
      npc_out = npc;
      sval = 16'd0;
      bytev = addr_ff[0] ? {8'd0, rdata_ff[15:8]} : {8'd0, rdata_ff[7:0]};
      unique case (opc)
         OP_ADD: begin rwr = 1'b1; cc_upd = 1'b1; rval = a_ff + b_ff; end
         OP_AND: begin rwr = 1'b1; cc_upd = 1'b1; rval = a_ff & b_ff; end
         OP_XOR: begin rwr = 1'b1; cc_upd = 1'b1; rval = a_ff ^ b_ff; end
         OP_BR: if ((dr & cc_ff) != 3'd0) npc_out = npc + {off9[14:0], 1'b0};
         OP_JMP: npc_out = a_ff;
         OP_JSR: begin
            rwr = 1'b1; ridx = 3'd7; rval = npc;
            npc_out = ins_ff[11] ? npc + {off11[14:0], 1'b0} : a_ff;
         end
         OP_LDB: begin
            rwr = 1'b1; cc_upd = 1'b1; rval = {{8{bytev[7]}}, bytev[7:0]};
         end
         OP_LDW: begin rwr = 1'b1; cc_upd = 1'b1; rval = rdata_ff; end
         OP_LEA: begin rwr = 1'b1; rval = npc + {off9[14:0], 1'b0}; end
         OP_SHF: begin
            rwr = 1'b1; cc_upd = 1'b1;
            if (!ins_ff[4]) rval = a_ff << ins_ff[3:0];
            else if (ins_ff[5]) rval = 16'($signed(a_ff) >>> ins_ff[3:0]);
            else rval = a_ff >> ins_ff[3:0];
         end
         OP_STB: begin sd = 1'b1; sval = {8'd0, src_ff[7:0]}; end
         OP_STW: begin sd = 1'b1; sval = src_ff; end
         OP_TRAP: begin rwr = 1'b1; ridx = 3'd7; rval = npc; npc_out = rdata_ff; end
         default: ;
      endcase
      cc_new = cc_ff;
      if (cc_upd) cc_new = (rval == 16'd0) ? 3'b010 : (rval[15] ? 3'b100 : 3'b001);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         pc_ff <= 16'd0;
         cc_ff <= CC_RESET;
         for (int i = 0; i < REG_COUNT; i++) regs_ff[i] <= 16'd0;
      end else begin
         if (cmd.clear_step && !status.clear_done) clr_ff <= clr_ff + 1'b1;
         if (cmd.set_pc) pc_ff <= req_start_pc;
         if (cmd.commit) begin
            pc_ff <= npc_out;
            cc_ff <= cc_new;
            if (rwr) regs_ff[RW'(ridx)] <= rval;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decode) begin
         ins_ff  <= ins_d;
         a_ff    <= a_in;
         b_ff    <= b_in;
         src_ff  <= regs_ff[RW'(ins_d[11:9])];
         addr_ff <= addr_in;
      end
      if (cmd.halt_result) begin
         res_ff <= '{halted: (req_kind == KIND_EXEC),
                     pc_after: (cmd.set_pc ? req_start_pc : pc_ff),
                     cond_nzp: cc_ff,
                     default: '0};
      end
      if (cmd.commit) begin
         res_ff.halted <= 1'b0;
         res_ff.pc_after <= npc_out;
         res_ff.opcode_done <= opc;
         res_ff.reg_written <= rwr;
         res_ff.reg_index <= rwr ? ridx : 3'd0;
         res_ff.reg_value <= rwr ? rval : 16'd0;
         res_ff.cond_nzp <= cc_new;
         res_ff.store_done <= sd;
         res_ff.store_address <= sd ? addr_ff : 16'd0;
         res_ff.store_value <= sval;
      end
   end

   assign result = res_ff;

   a_cc_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(cc_ff)) else $error("condition codes not one-hot");
   a_pc_hold: assert property (@(posedge clock) disable iff (reset)
      !$past(cmd.commit) && !$past(cmd.set_pc) |-> $stable(pc_ff))
      else $error("PC changed outside commit or set");
   a_clear_step: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_step |-> !cmd.commit && !cmd.load_word)
      else $error("memory write during clearing pass");
endmodule

FILE: rtl/lc3b_instruction_executor.sv
// Top level of the LC-3b instruction executor: controller and datapath.
// Depends on lc3b_pkg, lc3b_ctrl and lc3b_dpath.
//
//   Channel   Direction  Contents
//   req_*     in         kind, load word address/value, start PC
//   rsp_*     out        one result item per request item
//
// Load and set-PC items, and an execute item with PC zero, are handled in the
// accept step and then wait for result delivery. An executed instruction runs
// through accept with instruction fetch, decode with register read, data/vector
// read and commit. The single memory port sets this sequence.
// After reset a clearing pass writes zero to every memory word, during which
// no item is accepted. A new item is accepted once the result is taken.
module lc3b_instruction_executor #(
   parameter int MEM_WORDS = lc3b_pkg::MemWordsDefault,
   parameter int REG_COUNT = lc3b_pkg::RegCountDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // kind
   input  logic [47:0] req_tdata,   // load_word_address[14:0], load_word_value[30:15],
                                    // start_pc[46:31], zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata    // halted, pc_after, opcode_done, reg_written,
                                    // reg_index, reg_value, cond_nzp, store_done,
                                    // store_address, store_value, zero fill
);
   import lc3b_pkg::*;

   cmd_type    cmd;
   status_type status;
   result_type res;

   lc3b_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .req_kind(req_tuser),
      .rsp_tvalid, .rsp_tready, .status, .cmd
   );

   lc3b_dpath #(.MEM_WORDS(MEM_WORDS), .REG_COUNT(REG_COUNT)) u_dpath (
      .clock, .reset, .cmd, .status, .req_kind(req_tuser),
      .req_load_word_address(req_tdata[14:0]),
      .req_load_word_value(req_tdata[30:15]),
      .req_start_pc(req_tdata[46:31]),
      .result(res)
   );

   assign rsp_tdata = {3'd0, res.store_value, res.store_address, res.store_done,
                       res.cond_nzp, res.reg_value, res.reg_index, res.reg_written,
                       res.opcode_done, res.pc_after, res.halted};
endmodule

FILE: bench/tb.sv
// Self-checking bench for lc3b_instruction_executor: drives load, set-PC and
// execute items over the req_ stream and checks every rsp_ item against an
// in-bench instruction-level predictor. Depends on lc3b_pkg and the RTL top.
`timescale 1ns / 1ps

module tb;
   import lc3b_pkg::*;

   localparam int MemWords = 32768;
   localparam int CycleLimit = 400000;

   // Field order matches the request packing, start PC highest.
   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] start_pc;
      logic [15:0] word_value;
      logic [14:0] word_addr;
   } item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = '0;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;

   lc3b_instruction_executor dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predictor state.
   logic [15:0] gpr [8];
   logic [15:0] pc;
   logic [2:0]  nzp;
   logic [15:0] mem [MemWords];

   item_type   pending_items[$];
   result_type expected_results[$];
   int errors = 0;
   int cycles = 0;
   int executed = 0;
   int stores = 0;
   int halts = 0;
   bit quiet = 1'b0;
   bit hold_send = 1'b0;

   function automatic logic [15:0] sx(logic [15:0] v, int bits);
      logic [15:0] r;
      r = v & ((16'd1 << bits) - 16'd1);
      if (r[bits-1]) r = r | ~((16'd1 << bits) - 16'd1);
      return r;
   endfunction

   function automatic logic [2:0] cc_for(logic [15:0] v);
      if (v == 16'd0) return 3'b010;
      return v[15] ? 3'b100 : 3'b001;
   endfunction

   function automatic result_type execute_item(item_type it);
      result_type r;
      logic [15:0] ins, npc, a, b, addr, w;
      logic [31:0] wide;
      logic [2:0] dr;
      r = '0;
      if (it.kind == KIND_LOAD) begin
         mem[it.word_addr] = it.word_value;
      end else if (it.kind == KIND_SETPC) begin
         pc = it.start_pc;
      end else if (it.kind == KIND_EXEC) begin
         if (pc == 16'd0) begin
            r.halted = 1'b1;
         end else begin
            ins = mem[pc[15:1]];
            npc = pc + 16'd2;
            dr = ins[11:9];
            a = gpr[ins[8:6]];
            b = ins[5] ? sx(ins, 5) : gpr[ins[2:0]];
            r.opcode_done = ins[15:12];
            case (ins[15:12])
               OP_ADD: begin r.reg_written = 1; r.reg_value = a + b; end
               OP_AND: begin r.reg_written = 1; r.reg_value = a & b; end
               OP_XOR: begin r.reg_written = 1; r.reg_value = a ^ b; end
               OP_BR: if ((dr & nzp) != 0) npc = npc + (sx(ins, 9) << 1);
               OP_JMP: npc = a;
               OP_JSR: begin
                  r.reg_written = 1; r.reg_value = npc; dr = 3'd7;
                  npc = ins[11] ? npc + (sx(ins, 11) << 1) : a;
               end
               OP_LDB: begin
                  addr = a + sx(ins, 6);
                  w = mem[addr[15:1]];
                  w = addr[0] ? (w >> 8) : (w & 16'h00FF);
                  r.reg_written = 1; r.reg_value = sx(w, 8);
               end
               OP_LDW: begin
                  addr = a + (sx(ins, 6) << 1);
                  r.reg_written = 1; r.reg_value = mem[addr[15:1]];
               end
               OP_LEA: begin r.reg_written = 1; r.reg_value = npc + (sx(ins, 9) << 1); end
               OP_SHF: begin
                  if (!ins[4]) begin
                     w = a << ins[3:0];
                  end else begin
                     wide = {((ins[5] && a[15]) ? 16'hFFFF : 16'h0000), a};
                     wide = wide >> ins[3:0];
                     w = wide[15:0];
                  end
                  r.reg_written = 1; r.reg_value = w;
               end
               OP_STB: begin
                  addr = a + sx(ins, 6);
                  r.store_value = gpr[dr] & 16'h00FF;
                  w = mem[addr[15:1]];
                  w = addr[0] ? {r.store_value[7:0], w[7:0]} : {w[15:8], r.store_value[7:0]};
                  mem[addr[15:1]] = w;
                  r.store_done = 1; r.store_address = addr;
               end
               OP_STW: begin
                  addr = a + (sx(ins, 6) << 1);
                  r.store_value = gpr[dr];
                  mem[addr[15:1]] = r.store_value;
                  r.store_done = 1; r.store_address = addr;
               end
               OP_TRAP: begin
                  r.reg_written = 1; r.reg_value = npc; dr = 3'd7;
                  npc = mem[ins[7:0]];
               end
               default: ;
            endcase
            if (r.reg_written) begin
               r.reg_index = dr;
               gpr[dr] = r.reg_value;
               if (r.opcode_done != OP_LEA && r.opcode_done != OP_JSR &&
                   r.opcode_done != OP_TRAP)
                  nzp = cc_for(r.reg_value);
            end
            pc = npc;
         end
      end
      r.pc_after = pc;
      r.cond_nzp = nzp;
      return r;
   endfunction

   // Driver: one item per handshake, with random gaps.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(execute_item(item_type'({req_tuser, req_tdata[46:0]})));
            if (req_tuser == KIND_EXEC) executed++;
         end
         if ((!req_tvalid || req_tready) ) begin
            if (pending_items.size() > 0 && !hold_send &&
                (quiet || $urandom_range(99) >= 9)) begin
               item_type it;
               it = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= it.kind;
               req_tdata <= {1'b0, it.start_pc, it.word_value, it.word_addr};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= quiet || $urandom_range(99) >= 9;
      end
   end

   // Monitor: field-by-field comparison with the oldest expectation.
   always @(posedge clock) begin
      result_type got, want;
      cycles++;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[0], rsp_tdata[16:1], rsp_tdata[20:17], rsp_tdata[21],
                rsp_tdata[24:22], rsp_tdata[40:25], rsp_tdata[43:41], rsp_tdata[44],
                rsp_tdata[60:45], rsp_tdata[76:61]};
         if (expected_results.size() == 0) begin
            $error("result item with nothing expected");
            errors++;
         end else begin
            want = expected_results.pop_front();
            if (want.halted) halts++;
            if (want.store_done) stores++;
            if (got.halted != want.halted) begin
               $error("halted: expected %0h got %0h", want.halted, got.halted); errors++;
            end
            if (got.pc_after != want.pc_after) begin
               $error("pc_after: expected %0h got %0h", want.pc_after, got.pc_after); errors++;
            end
            if (got.opcode_done != want.opcode_done) begin
               $error("opcode_done: expected %0h got %0h", want.opcode_done, got.opcode_done);
               errors++;
            end
            if (got.reg_written != want.reg_written) begin
               $error("reg_written: expected %0h got %0h", want.reg_written, got.reg_written);
               errors++;
            end
            if (got.reg_index != want.reg_index) begin
               $error("reg_index: expected %0h got %0h", want.reg_index, got.reg_index); errors++;
            end
            if (got.reg_value != want.reg_value) begin
               $error("reg_value: expected %0h got %0h", want.reg_value, got.reg_value); errors++;
            end
            if (got.cond_nzp != want.cond_nzp) begin
               $error("cond_nzp: expected %0h got %0h", want.cond_nzp, got.cond_nzp); errors++;
            end
            if (got.store_done != want.store_done) begin
               $error("store_done: expected %0h got %0h", want.store_done, got.store_done);
               errors++;
            end
            if (got.store_address != want.store_address) begin
               $error("store_address: expected %0h got %0h", want.store_address,
                      got.store_address);
               errors++;
            end
            if (got.store_value != want.store_value) begin
               $error("store_value: expected %0h got %0h", want.store_value, got.store_value);
               errors++;
            end
         end
      end
      if (cycles > CycleLimit) begin
         $display("timeout with %0d results outstanding", expected_results.size());
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic item_type load_item(logic [14:0] waddr, logic [15:0] value);
      item_type it;
      it = '0;
      it.kind = KIND_LOAD; it.word_addr = waddr; it.word_value = value;
      return it;
   endfunction

   function automatic item_type setpc_item(logic [15:0] target);
      item_type it;
      it = '0;
      it.kind = KIND_SETPC; it.start_pc = target;
      return it;
   endfunction

   function automatic item_type exec_item();
      item_type it;
      it = '0;
      it.kind = KIND_EXEC;
      return it;
   endfunction

   // Random instruction; the low six bits are redrawn at random most of the time.
   function automatic logic [15:0] random_instruction();
      logic [15:0] ins;
      ins = 16'($urandom);
      if ($urandom_range(3) != 0) ins[5:0] = 6'($urandom_range(63));
      return ins;
   endfunction

   task automatic queue_wait_empty();
      while (pending_items.size() > 0) @(posedge clock);
   endtask

   initial begin
      int i, j, n;
      logic [14:0] base;
      bit paused;
      paused = 1'b0;
      for (i = 0; i < 8; i++) gpr[i] = '0;
      for (i = 0; i < MemWords; i++) mem[i] = '0;
      pc = '0;
      nzp = CC_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: halted step, field extremes, several opcodes, special cases.
      pending_items.push_back(exec_item());
      pending_items.push_back(load_item(15'h7FFF, 16'hFFFF));
      pending_items.push_back(load_item(15'h0000, 16'h0000));
      pending_items.push_back(setpc_item(16'hFFFF));
      pending_items.push_back(exec_item());                 // word FFFF is a TRAP
      pending_items.push_back(load_item(15'h0100, {OP_ADD, 3'd1, 3'd0, 1'b1, 5'h1F}));
      pending_items.push_back(load_item(15'h0101, {OP_SHF, 3'd2, 3'd1, 2'b11, 4'hF}));
      pending_items.push_back(load_item(15'h0102, {OP_SHF, 3'd3, 3'd1, 2'b10, 4'h4}));
      pending_items.push_back(load_item(15'h0103, {OP_STB, 3'd1, 3'd0, 6'h21}));
      pending_items.push_back(load_item(15'h0104, {OP_LDB, 3'd4, 3'd0, 6'h21}));
      pending_items.push_back(load_item(15'h0105, {OP_BR, 3'b000, 9'h1FF}));
      pending_items.push_back(load_item(15'h0106, {OP_BR, 3'b100, 9'h001}));
      pending_items.push_back(load_item(15'h0108, {OP_JSR, 1'b0, 2'b00, 3'd1, 6'h00}));
      pending_items.push_back(setpc_item(16'h0200));
      for (i = 0; i < 8; i++) pending_items.push_back(exec_item());
      pending_items.push_back(exec_item());
      queue_wait_empty();

      // Random: short well-formed programs with random content, plus noise.
      n = 0;
      while (n < 880) begin
         quiet = (n >= 300 && n < 420);
         if (n >= 600 && !paused) begin
            // Pause until everything issued has come back.
            paused = 1'b1;
            queue_wait_empty();
            hold_send = 1'b1;
            while (expected_results.size() > 0 || req_tvalid) @(posedge clock);
            hold_send = 1'b0;
         end
         if ($urandom_range(9) == 0) begin
            pending_items.push_back(load_item(15'($urandom), 16'($urandom)));
            n++;
            continue;
         end
         base = 15'($urandom_range(64, 1024));
         j = $urandom_range(2, 8);
         for (i = 0; i < j; i++)
            pending_items.push_back(load_item(base + 15'(i), random_instruction()));
         // Trap vectors and data words near low memory.
         pending_items.push_back(load_item(15'($urandom_range(255)),
                                           {base, 1'b0} + 16'($urandom_range(6))));
         pending_items.push_back(setpc_item($urandom_range(7) == 0 ? 16'($urandom)
                                            : {base, $urandom_range(1) == 0 ? 1'b0 : 1'b1}));
         for (i = 0; i < j + 1; i++) pending_items.push_back(exec_item());
         if ($urandom_range(15) == 0) pending_items.push_back(setpc_item(16'h0000));
         n += 2 * j + 3;
         if (pending_items.size() > 40) queue_wait_empty();
      end
      quiet = 1'b0;
      queue_wait_empty();
      while (expected_results.size() > 0 || req_tvalid) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Ran %0d execute steps (%0d halted, %0d stores) plus memory and PC loads.",
               executed, halts, stores);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
